/* sv/spl_pkg.sv */
// Shared constants and types for the spline segment evaluator.
package spl_pkg;

  localparam int unsigned COORD_BITS_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  // Extra accumulator bits above the coordinate width (Bezier sums reach ~29x range).
  localparam int unsigned GUARD_BITS = 6;

  // input capture, coefficient build, three Horner steps of abs/mul/round-add
  localparam int unsigned NUM_STAGES = 2 + 3 * 3;
  // edges from the accepting edge until the strobe is sampled
  localparam int unsigned LATENCY    = NUM_STAGES + 1;

  typedef enum logic [1:0] {
    MODE_HERMITE = 2'd0,
    MODE_BEZIER3 = 2'd1,
    MODE_BEZIER2 = 2'd2
  } curve_mode_e;

endpackage

/* sv/spline_segment_evaluator.sv */
// Spline segment evaluator: pipelined Horner evaluation of one curve coordinate.
// The result strobe follows start through the valid_q shift register and the result register.
// Throughput: one word per cycle; busy_o is never raised, the pipeline has no stalls.
// Depth: capture, coefficient build, three Horner steps of abs, multiplier, round-add.
// Reset clears the valid bits and the result strobe; curve mode resets to cubic Hermite.
module spline_segment_evaluator #(
  parameter int unsigned COORD_BITS = spl_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = spl_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  curve_mode_we_i,
  input  logic [1:0]            curve_mode_i,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [FRAC_BITS-1:0]  fraction_i,
  input  logic [COORD_BITS-1:0] start_point_i,
  input  logic [COORD_BITS-1:0] start_tangent_i,
  input  logic [COORD_BITS-1:0] end_point_i,
  input  logic [COORD_BITS-1:0] end_tangent_i,
  input  logic                  has_end_i,
  output logic                  result_valid_o,
  output logic [COORD_BITS-1:0] curve_value_o,
  output logic                  saturated_o
);
  import spl_pkg::*;

  localparam int unsigned C    = COORD_BITS;
  localparam int unsigned F    = FRAC_BITS;
  localparam int unsigned W    = COORD_BITS + GUARD_BITS;
  localparam int unsigned NSTG = NUM_STAGES;
  localparam logic [W+F-1:0] HALF = {{W{1'b0}}, 1'b1, {(F-1){1'b0}}};

  typedef struct packed {
    logic           bypass;
    logic [1:0]     mode;
    logic [F-1:0]   s;
    logic [W-1:0]   p1;
    logic [W-1:0]   t1;
    logic [W-1:0]   t2;
    logic [W-1:0]   dp;
    logic [W-1:0]   c1;
    logic [W-1:0]   c2;
    logic [W-1:0]   acc;
    logic           neg;
    logic [W+F-1:0] prod;
  } pipe_t;

  logic [1:0]      curve_mode_q;
  logic [NSTG-1:0] valid_q;
  pipe_t           stage_q [NSTG];
  pipe_t           stage_d [NSTG];

  logic            result_valid_q;
  logic [C-1:0]    curve_value_d, curve_value_q;
  logic            saturated_d, saturated_q;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      curve_mode_q <= MODE_HERMITE;
    end else if (curve_mode_we_i) begin
      curve_mode_q <= curve_mode_i;
    end
  end

  // capture, sign extend, end minus start
  always_comb begin
    logic [W-1:0] p1x, p2x;
    p1x = {{(W-C){start_point_i[C-1]}}, start_point_i};
    p2x = {{(W-C){end_point_i[C-1]}}, end_point_i};
    stage_d[0]        = '0;
    stage_d[0].bypass = ~has_end_i;
    stage_d[0].mode   = curve_mode_q;
    stage_d[0].s      = fraction_i;
    stage_d[0].p1     = p1x;
    stage_d[0].t1     = {{(W-C){start_tangent_i[C-1]}}, start_tangent_i};
    stage_d[0].t2     = {{(W-C){end_tangent_i[C-1]}}, end_tangent_i};
    stage_d[0].dp     = p2x - p1x;
  end

  // polynomial coefficients; c3 goes to the accumulator
  always_comb begin
    logic [W-1:0] t1, t2, dp, two_t1, two_dp, x, y;
    t1     = stage_q[0].t1;
    t2     = stage_q[0].t2;
    dp     = stage_q[0].dp;
    two_t1 = {t1[W-2:0], 1'b0};
    two_dp = {dp[W-2:0], 1'b0};
    x      = dp - two_t1 + t2;
    y      = t1 - t2;
    stage_d[1] = stage_q[0];
    unique case (stage_q[0].mode)
      MODE_BEZIER3: begin
        stage_d[1].c1  = two_t1 + t1;
        stage_d[1].c2  = {x[W-2:0], 1'b0} + x;
        stage_d[1].acc = {y[W-2:0], 1'b0} + y - two_dp;
      end
      MODE_BEZIER2: begin
        stage_d[1].c1  = two_t1;
        stage_d[1].c2  = dp - two_t1;
        stage_d[1].acc = '0;
      end
      default: begin
        stage_d[1].c1  = t1;
        stage_d[1].c2  = two_dp + dp - two_t1 - t2;
        stage_d[1].acc = t1 + t2 - two_dp;
      end
    endcase
  end

  for (genvar j = 0; j < 3; j++) begin : g_horner
    localparam int unsigned B = 2 + 3 * j;

    // sign and magnitude
    always_comb begin
      stage_d[B]     = stage_q[B-1];
      stage_d[B].neg = stage_q[B-1].acc[W-1];
      stage_d[B].acc = stage_q[B-1].acc[W-1] ? -stage_q[B-1].acc : stage_q[B-1].acc;
    end

    // magnitude times fraction
    always_comb begin
      stage_d[B+1]      = stage_q[B];
      stage_d[B+1].prod = stage_q[B].acc * stage_q[B].s;
    end

    // round half away from zero, restore sign, add next coefficient
    always_comb begin
      logic [W+F-1:0] sum;
      logic [W-1:0]   r, rs, addend;
      sum = stage_q[B+1].prod + HALF;
      r   = sum[W+F-1:F];
      rs  = stage_q[B+1].neg ? -r : r;
      if (j == 0) begin
        addend = stage_q[B+1].c2;
      end else if (j == 1) begin
        addend = stage_q[B+1].c1;
      end else begin
        addend = stage_q[B+1].p1;
      end
      stage_d[B+2]     = stage_q[B+1];
      stage_d[B+2].acc = addend + rs;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[NSTG-2:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NSTG; k++) begin
      stage_q[k] <= stage_d[k];
    end
  end

  // clamp to the coordinate range; without an end node pass the start point
  always_comb begin
    logic [W-1:0]   acc;
    logic [W-C:0]   upper;
    acc   = stage_q[NSTG-1].acc;
    upper = acc[W-1:C-1];
    if (stage_q[NSTG-1].bypass) begin
      curve_value_d = stage_q[NSTG-1].p1[C-1:0];
      saturated_d   = 1'b0;
    end else if ((&upper) || !(|upper)) begin
      curve_value_d = acc[C-1:0];
      saturated_d   = 1'b0;
    end else begin
      curve_value_d = acc[W-1] ? {1'b1, {(C-1){1'b0}}} : {1'b0, {(C-1){1'b1}}};
      saturated_d   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= valid_q[NSTG-1];
    end
  end

  always_ff @(posedge clk_i) begin
    curve_value_q <= curve_value_d;
    saturated_q   <= saturated_d & valid_q[NSTG-1];
  end

  assign result_valid_o = result_valid_q;
  assign curve_value_o  = curve_value_q;
  assign saturated_o    = saturated_q;

endmodule

/* sv/spl_chk.sv */
// Port-level assertions for the spline segment evaluator, bound to the top level.
module spl_chk #(
  parameter int unsigned COORD_BITS = spl_pkg::COORD_BITS_DEF
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  start_i,
  input logic                  busy_o,
  input logic [COORD_BITS-1:0] start_point_i,
  input logic                  has_end_i,
  input logic                  result_valid_o,
  input logic [COORD_BITS-1:0] curve_value_o,
  input logic                  saturated_o
);
  import spl_pkg::*;

  localparam int unsigned CW = $clog2(LATENCY + 1);
  localparam logic [CW-1:0] WARM = CW'(LATENCY);

  logic [CW-1:0] warm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warm_q <= '0;
    end else if (warm_q != WARM) begin
      warm_q <= warm_q + 1'b1;
    end
  end

  a_strobe_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (warm_q == WARM) |-> (result_valid_o == $past(start_i && !busy_o, LATENCY)))
    else $error("result strobe not aligned with accepted word");

  a_no_end_passes_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && !has_end_i) |-> ##LATENCY
    (result_valid_o && !saturated_o && curve_value_o == $past(start_point_i, LATENCY)))
    else $error("segment without end node did not return start point");

  a_sat_only_with_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    saturated_o |-> result_valid_o)
    else $error("saturated flag without result strobe");

  a_sat_at_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    saturated_o |-> (curve_value_o == {1'b1, {(COORD_BITS-1){1'b0}}} ||
                     curve_value_o == {1'b0, {(COORD_BITS-1){1'b1}}}))
    else $error("saturated result not at a range bound");

endmodule

bind spline_segment_evaluator spl_chk #(
  .COORD_BITS(COORD_BITS)
) u_spl_chk (.*);

/* bench/spline_segment_evaluator_tb.sv */
// Self-checking testbench for spline_segment_evaluator: directed table, random segments, predictor.
module spline_segment_evaluator_tb;
  import spl_pkg::*;

  localparam logic [1:0]  MODE_SPARE  = 2'd3;
  localparam logic [31:0] COORD_MAX_W = 32'h7FFF_FFFF;
  localparam logic [31:0] COORD_MIN_W = 32'h8000_0000;
  localparam longint      COORD_MAX   = 64'sd2147483647;
  localparam longint      COORD_MIN   = -COORD_MAX - 1;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned WORDS_PER_PHASE = 232;
  localparam logic [7:0][1:0] PHASE_MODES = {
    MODE_BEZIER2, MODE_HERMITE, MODE_BEZIER3, MODE_BEZIER2,
    MODE_SPARE, MODE_BEZIER3, MODE_HERMITE, MODE_BEZIER2
  };

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] frac;
    logic [31:0] p1;
    logic [31:0] t1;
    logic [31:0] p2;
    logic [31:0] t2;
    logic        has_end;
    logic        typed;
    logic [31:0] exp_value;
    logic        exp_sat;
  } segment_word_t;

  typedef struct packed {
    logic [31:0] value;
    logic        sat;
  } curve_point_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        curve_mode_we_i = 1'b0;
  logic [1:0]  curve_mode_i = MODE_HERMITE;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [15:0] fraction_i = '0;
  logic [31:0] start_point_i = '0;
  logic [31:0] start_tangent_i = '0;
  logic [31:0] end_point_i = '0;
  logic [31:0] end_tangent_i = '0;
  logic        has_end_i = 1'b0;
  logic        result_valid_o;
  logic [31:0] curve_value_o;
  logic        saturated_o;

  // typed expectation travels with the word
  logic        word_typed = 1'b0;
  logic [31:0] word_exp_value = '0;
  logic        word_exp_sat = 1'b0;

  logic [1:0]   mode_model = MODE_HERMITE;
  logic [1:0]   mode_set = MODE_HERMITE;
  curve_point_t expected_points[$];
  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count = 0;

  segment_word_t directed_rows [19] = '{
    '{MODE_HERMITE, 16'h1234, 32'h1234_5678, COORD_MAX_W, COORD_MIN_W, 32'h1, 1'b0,
      1'b1, 32'h1234_5678, 1'b0},
    '{MODE_HERMITE, 16'h0000, COORD_MIN_W, COORD_MAX_W, COORD_MAX_W, COORD_MIN_W, 1'b1,
      1'b1, COORD_MIN_W, 1'b0},
    '{MODE_HERMITE, 16'hFFFF, COORD_MAX_W, COORD_MAX_W, COORD_MAX_W, COORD_MAX_W, 1'b1,
      1'b0, 32'h0, 1'b0},
    '{MODE_HERMITE, 16'hFFFF, COORD_MIN_W, COORD_MIN_W, COORD_MIN_W, COORD_MIN_W, 1'b1,
      1'b0, 32'h0, 1'b0},
    '{MODE_HERMITE, 16'h8000, 32'h0001_0000, 32'h0002_0000, 32'hFFFE_0000, 32'h0000_8000, 1'b1,
      1'b0, 32'h0, 1'b0},
    '{MODE_HERMITE, 16'hFFFF, COORD_MAX_W, 32'h0, 32'h0, 32'h0, 1'b0,
      1'b1, COORD_MAX_W, 1'b0},
    '{MODE_BEZIER3, 16'h0000, COORD_MAX_W, COORD_MIN_W, COORD_MIN_W, COORD_MAX_W, 1'b1,
      1'b1, COORD_MAX_W, 1'b0},
    '{MODE_BEZIER3, 16'hFFFF, COORD_MAX_W, COORD_MAX_W, COORD_MAX_W, COORD_MAX_W, 1'b1,
      1'b0, 32'h0, 1'b0},
    '{MODE_BEZIER3, 16'hFFFF, COORD_MIN_W, COORD_MIN_W, COORD_MIN_W, COORD_MIN_W, 1'b1,
      1'b0, 32'h0, 1'b0},
    '{MODE_BEZIER3, 16'h4000, 32'h0003_0000, 32'hFFFF_0000, 32'h0005_8000, 32'h0001_0000, 1'b1,
      1'b0, 32'h0, 1'b0},
    '{MODE_BEZIER3, 16'h8000, COORD_MIN_W, COORD_MAX_W, COORD_MAX_W, COORD_MIN_W, 1'b0,
      1'b1, COORD_MIN_W, 1'b0},
    '{MODE_BEZIER2, 16'hFFFF, COORD_MAX_W, COORD_MAX_W, COORD_MAX_W, 32'h0, 1'b1,
      1'b1, COORD_MAX_W, 1'b1},
    '{MODE_BEZIER2, 16'hFFFF, COORD_MIN_W, COORD_MIN_W, COORD_MIN_W, 32'h0, 1'b1,
      1'b1, COORD_MIN_W, 1'b1},
    '{MODE_BEZIER2, 16'h0001, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0010, COORD_MAX_W, 1'b1,
      1'b0, 32'h0, 1'b0},
    '{MODE_BEZIER2, 16'h8000, 32'hDEAD_BEEF, 32'h0, 32'h0, 32'h0, 1'b0,
      1'b1, 32'hDEAD_BEEF, 1'b0},
    '{MODE_SPARE, 16'h8000, 32'h0001_0000, 32'h0002_0000, 32'hFFFE_0000, 32'h0000_8000, 1'b1,
      1'b0, 32'h0, 1'b0},
    '{MODE_SPARE, 16'hFFFF, COORD_MAX_W, COORD_MAX_W, COORD_MAX_W, COORD_MAX_W, 1'b1,
      1'b0, 32'h0, 1'b0},
    '{MODE_SPARE, 16'h0000, 32'h0, COORD_MAX_W, COORD_MIN_W, COORD_MAX_W, 1'b0,
      1'b1, 32'h0, 1'b0},
    '{MODE_HERMITE, 16'h8000, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1,
      1'b0, 32'h0, 1'b0}
  };

  spline_segment_evaluator i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .curve_mode_we_i (curve_mode_we_i),
    .curve_mode_i    (curve_mode_i),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .fraction_i      (fraction_i),
    .start_point_i   (start_point_i),
    .start_tangent_i (start_tangent_i),
    .end_point_i     (end_point_i),
    .end_tangent_i   (end_tangent_i),
    .has_end_i       (has_end_i),
    .result_valid_o  (result_valid_o),
    .curve_value_o   (curve_value_o),
    .saturated_o     (saturated_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // a*s / 2^16, rounded to nearest, ties away from zero
  function automatic longint scale_by_fraction(input longint a, input logic [15:0] s);
    logic [63:0] mag;
    logic [63:0] q;
    mag = (a < 0) ? -a : a;
    q = (mag * s + 64'd32768) >> 16;
    return (a < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic curve_point_t blend_segment(input logic [1:0] mode, input logic [15:0] s,
                                                 input logic [31:0] p1_w, input logic [31:0] t1_w,
                                                 input logic [31:0] p2_w, input logic [31:0] t2_w,
                                                 input logic has_end);
    longint p1, t1, p2, t2, c1, c2, c3, acc;
    curve_point_t pt;
    p1 = $signed(p1_w);
    t1 = $signed(t1_w);
    p2 = $signed(p2_w);
    t2 = $signed(t2_w);
    if (!has_end) begin
      pt.value = p1_w;
      pt.sat = 1'b0;
      return pt;
    end
    case (mode)
      MODE_BEZIER3: begin
        c1 = 3 * t1;
        c2 = 3 * (p2 - p1 - 2 * t1 + t2);
        c3 = 2 * p1 - 2 * p2 + 3 * t1 - 3 * t2;
      end
      MODE_BEZIER2: begin
        c1 = 2 * t1;
        c2 = p2 - p1 - 2 * t1;
        c3 = 0;
      end
      default: begin
        c1 = t1;
        c2 = 3 * p2 - 3 * p1 - 2 * t1 - t2;
        c3 = 2 * p1 - 2 * p2 + t1 + t2;
      end
    endcase
    acc = c2 + scale_by_fraction(c3, s);
    acc = c1 + scale_by_fraction(acc, s);
    acc = p1 + scale_by_fraction(acc, s);
    pt.sat = 1'b1;
    if (acc > COORD_MAX) acc = COORD_MAX;
    else if (acc < COORD_MIN) acc = COORD_MIN;
    else pt.sat = 1'b0;
    pt.value = acc[31:0];
    return pt;
  endfunction

  always @(posedge clk_i) begin
    curve_point_t want;
    cycle_count++;
    if (rst_ni) begin
      if (result_valid_o) begin
        if (expected_points.size() == 0) begin
          $display("%0t: unexpected word curve_value %h saturated %b",
                   $time, curve_value_o, saturated_o);
          mismatch_count++;
        end else begin
          want = expected_points.pop_front();
          if (curve_value_o !== want.value) begin
            $display("%0t: curve_value expected %h actual %h", $time, want.value, curve_value_o);
            mismatch_count++;
          end
          if (saturated_o !== want.sat) begin
            $display("%0t: saturated expected %b actual %b", $time, want.sat, saturated_o);
            mismatch_count++;
          end
        end
      end
      if (start_i && !busy_o) begin
        if (word_typed) begin
          want.value = word_exp_value;
          want.sat = word_exp_sat;
        end else begin
          want = blend_segment(mode_model, fraction_i, start_point_i, start_tangent_i,
                               end_point_i, end_tangent_i, has_end_i);
        end
        expected_points = {expected_points, want};
      end
      if (curve_mode_we_i) mode_model = curve_mode_i;
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_word(input segment_word_t w, input bit may_idle);
    while (may_idle && $urandom_range(99) < 31) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i         <= 1'b1;
    fraction_i      <= w.frac;
    start_point_i   <= w.p1;
    start_tangent_i <= w.t1;
    end_point_i     <= w.p2;
    end_tangent_i   <= w.t2;
    has_end_i       <= w.has_end;
    word_typed      <= w.typed;
    word_exp_value  <= w.exp_value;
    word_exp_sat    <= w.exp_sat;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic drain_pipeline();
    start_i <= 1'b0;
    do @(posedge clk_i); while (expected_points.size() != 0);
  endtask

  task automatic write_curve_mode(input logic [1:0] m);
    drain_pipeline();
    curve_mode_we_i <= 1'b1;
    curve_mode_i    <= m;
    @(posedge clk_i);
    curve_mode_we_i <= 1'b0;
    mode_set = m;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(9))
      0, 1, 2: return $urandom();
      3: begin
        case ($urandom_range(4))
          0: return COORD_MAX_W;
          1: return COORD_MIN_W;
          2: return 32'h0;
          3: return 32'h1;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return 32'($urandom_range(32'h007F_FFFF)) - 32'h0040_0000;
    endcase
  endfunction

  function automatic logic [15:0] rand_fraction();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      default: return 16'($urandom());
    endcase
  endfunction

  initial begin
    segment_word_t w;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].mode != mode_set) write_curve_mode(directed_rows[i].mode);
      send_word(directed_rows[i], 1'b1);
    end

    for (int p = 0; p < 8; p++) begin
      write_curve_mode(PHASE_MODES[p]);
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        w = '0;
        w.frac    = rand_fraction();
        w.p1      = rand_coord();
        w.t1      = rand_coord();
        w.p2      = rand_coord();
        w.t2      = rand_coord();
        w.has_end = ($urandom_range(99) < 85);
        send_word(w, p != 2);
      end
    end

    drain_pipeline();
    repeat (LATENCY + 4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
